[hdl/lct_pkg.sv]
// Package for the LFU cache table: field widths, operation codes, the stored
// entry layout and the scan status bundle.
// Depends on nothing; lct_ifs, lct_scan and the top level import it.
package lct_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   localparam int KEY_W     = 32;
   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 32;
   localparam int STAMP_W   = 48;
   localparam int CAP_CFG_W = 5;

   localparam logic [CAP_CFG_W-1:0] CAP_CFG_RESET = CAP_CFG_W'(16);

   // Operation codes carried in the kind field.
   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   typedef logic signed [KEY_W-1:0]   key_type;
   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0]        count_type;
   typedef logic [STAMP_W-1:0]        stamp_type;

   // One slot of the table as it sits in memory.
   typedef struct packed {
      key_type   key;
      value_type value;
      count_type use_count;
      stamp_type stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // What the scan found for the key of the current word.
   typedef struct packed {
      logic      match;
      entry_type match_entry;
   } scan_status_type;

   // Use counts stop at their maximum instead of wrapping.
   function automatic count_type sat_inc(input count_type c);
      return (&c) ? c : c + COUNT_W'(1);
   endfunction

endpackage

[hdl/lct_ifs.sv]
// Valid/ready channel interfaces for the request and response words of the
// LFU cache table. Depends on lct_pkg for the payload types.
interface lct_req_if;
   import lct_pkg::*;

   logic      valid;
   logic      ready;
   logic      kind;
   key_type   key;
   value_type write_value;

   modport source (output valid, output kind, output key, output write_value, input ready);
   modport sink   (input valid, input kind, input key, input write_value, output ready);
endinterface

interface lct_rsp_if;
   import lct_pkg::*;

   logic      valid;
   logic      ready;
   logic      hit;
   value_type read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

[hdl/lct_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. No dependencies.
module lct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/lct_scan.sv]
// Scan unit: looks at one table entry per cycle while rd_valid is high, as it
// comes out of memory, remembers the entry whose key matches and tracks the
// eviction victim. Depends on lct_pkg.
module lct_scan #(
   parameter int CAPACITY = lct_pkg::CAPACITY_DEFAULT,
   localparam int IDX_W = $clog2(CAPACITY > 1 ? CAPACITY : 2)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     rd_valid,
   input  logic [IDX_W-1:0]         rd_idx,
   input  lct_pkg::entry_type       rd_entry,
   input  lct_pkg::key_type         key,
   output lct_pkg::scan_status_type status,
   output logic [IDX_W-1:0]         match_idx,
   output logic [IDX_W-1:0]         victim_idx
);
   import lct_pkg::*;

   logic             match_ff, match_in;
   entry_type        match_entry_ff, match_entry_in;
   logic [IDX_W-1:0] match_idx_ff, match_idx_in;
   logic             have_ff, have_in;
   count_type        best_count_ff, best_count_in;
   stamp_type        best_stamp_ff, best_stamp_in;
   logic [IDX_W-1:0] victim_idx_ff, victim_idx_in;
   logic             better;

   // Lower count wins; among equal counts the older stamp wins.
   assign better = !have_ff ||
                   (rd_entry.use_count < best_count_ff) ||
                   ((rd_entry.use_count == best_count_ff) &&
                    (rd_entry.stamp < best_stamp_ff));

   always_comb begin
      match_in       = match_ff;
      match_entry_in = match_entry_ff;
      match_idx_in   = match_idx_ff;
      have_in        = have_ff;
      best_count_in  = best_count_ff;
      best_stamp_in  = best_stamp_ff;
      victim_idx_in  = victim_idx_ff;
      if (clear) begin
         match_in = 1'b0;
         have_in  = 1'b0;
      end else if (rd_valid) begin
         if (rd_entry.key == key) begin
            match_in       = 1'b1;
            match_entry_in = rd_entry;
            match_idx_in   = rd_idx;
         end
         if (better) begin
            have_in       = 1'b1;
            best_count_in = rd_entry.use_count;
            best_stamp_in = rd_entry.stamp;
            victim_idx_in = rd_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_ff <= 1'b0;
         have_ff  <= 1'b0;
      end else begin
         match_ff <= match_in;
         have_ff  <= have_in;
      end
      match_entry_ff <= match_entry_in;
      match_idx_ff   <= match_idx_in;
      best_count_ff  <= best_count_in;
      best_stamp_ff  <= best_stamp_in;
      victim_idx_ff  <= victim_idx_in;
   end

   assign status.match       = match_ff;
   assign status.match_entry = match_entry_ff;
   assign match_idx          = match_idx_ff;
   assign victim_idx         = victim_idx_ff;

endmodule

[hdl/lfu_cache_table_top.sv]
// LFU cache table, top level. Each request word is a get or a put of a
// 32-bit key. A get returns hit and the stored value (or -1 on a miss) and
// bumps the entry's use count and recency stamp; a put updates a present key
// the same way, or inserts a new key with count 1, evicting first the entry
// with the lowest count and, among equal counts, the oldest stamp when the
// table holds its limit, which is min(csr_wdata as last written, CAPACITY).
// Every request gives exactly one response word. The slots live in one
// synchronous RAM and are kept packed from slot 0 upward, so the fill count
// alone says which slots hold data and no clearing pass is needed after
// reset. With a limit of 0 a put of a new key stores nothing. A request
// first issues a read from the RAM for each occupied slot in turn, lets the
// last read land in the match and victim tracker, sees the read pipe
// drained, and then writes back and loads the response register; an empty
// table issues no read. The block works on one request at a time and takes
// the next only once it is back in idle; a finished response waits in its
// output register while the next request is accepted, and write-back of
// that next request holds until the response has been taken. Depends on
// lct_pkg, lct_ifs, lct_ram and lct_scan.
module lfu_cache_table_top #(
   parameter int CAPACITY = lct_pkg::CAPACITY_DEFAULT
) (
   input logic                            clock,
   input logic                            reset,
   lct_req_if.sink                        req,
   lct_rsp_if.source                      rsp,
   input logic                            csr_we,
   input logic [lct_pkg::CAP_CFG_W-1:0]   csr_wdata
);
   import lct_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY > 1 ? CAPACITY : 2);
   localparam int OCC_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (OCC_W > CAP_CFG_W) ? OCC_W : CAP_CFG_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   logic [OCC_W-1:0]     issue_ff, issue_in;
   logic                 rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   stamp_type            clock_ff, clock_in;
   logic [CAP_CFG_W-1:0] cap_ff, cap_in;

   // The accepted request word is held for the whole operation.
   logic                 kind_ff;
   key_type              key_ff;
   value_type            wval_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff, rsp_hit_in;
   value_type            rsp_value_ff, rsp_value_in;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   entry_type            ram_wdata;
   entry_type            ram_rdata;

   scan_status_type      scan_status;
   logic [IDX_W-1:0]     match_idx;
   logic [IDX_W-1:0]     victim_idx;

   logic                 accept;
   logic                 fire;
   logic [CMP_W-1:0]     cap_ext;
   logic [CMP_W-1:0]     limit;
   logic [CMP_W-1:0]     occ_ext;
   entry_type            bumped;
   entry_type            fresh;

   assign accept  = req.valid && req.ready;
   assign fire    = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp.ready);
   assign cap_ext = CMP_W'(cap_ff);
   assign limit   = (cap_ext < CMP_W'(CAPACITY)) ? cap_ext : CMP_W'(CAPACITY);
   assign occ_ext = CMP_W'(occ_ff);

   assign req.ready = (state_ff == ST_IDLE);

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.hit        = rsp_hit_ff;
   assign rsp.read_value = rsp_value_ff;

   // A hit keeps its key, takes the new value on a put and gets bumped.
   always_comb begin
      bumped.key       = key_ff;
      bumped.value     = (kind_ff == KIND_PUT) ? wval_ff : scan_status.match_entry.value;
      bumped.use_count = sat_inc(scan_status.match_entry.use_count);
      bumped.stamp     = clock_ff;
      fresh.key        = key_ff;
      fresh.value      = wval_ff;
      fresh.use_count  = COUNT_W'(1);
      fresh.stamp      = clock_ff;
   end

   lct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   lct_scan #(
      .CAPACITY (CAPACITY)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .clear      (accept),
      .rd_valid   (rd_pend_ff),
      .rd_idx     (rd_idx_ff),
      .rd_entry   (ram_rdata),
      .key        (key_ff),
      .status     (scan_status),
      .match_idx  (match_idx),
      .victim_idx (victim_idx)
   );

   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      rd_pend_in   = 1'b0;
      rd_idx_in    = rd_idx_ff;
      occ_in       = occ_ff;
      clock_in     = clock_ff;
      cap_in       = csr_we ? csr_wdata : cap_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;
      ram_we       = 1'b0;
      ram_waddr    = match_idx;
      ram_wdata    = bumped;

      case (state_ff)
         ST_IDLE: begin
            issue_in = '0;
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Occupied slots are exactly 0 .. occupancy-1; read them in turn.
            if (issue_ff < occ_ff) begin
               issue_in   = issue_ff + OCC_W'(1);
               rd_pend_in = 1'b1;
               rd_idx_in  = issue_ff[IDX_W-1:0];
            end else if (!rd_pend_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (fire) begin
               state_in     = ST_IDLE;
               clock_in     = clock_ff + STAMP_W'(1);
               rsp_valid_in = 1'b1;
               rsp_hit_in   = scan_status.match;
               if (kind_ff == KIND_GET) begin
                  rsp_value_in = scan_status.match ? scan_status.match_entry.value : '1;
               end else begin
                  rsp_value_in = '0;
               end
               if (scan_status.match) begin
                  ram_we = 1'b1;
               end else if ((kind_ff == KIND_PUT) && (limit != '0)) begin
                  // New key: take the next free slot while below the limit,
                  // otherwise overwrite the victim in place.
                  ram_we    = 1'b1;
                  ram_wdata = fresh;
                  if (occ_ext < limit) begin
                     ram_waddr = occ_ff[IDX_W-1:0];
                     occ_in    = occ_ff + OCC_W'(1);
                  end else begin
                     ram_waddr = victim_idx;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         occ_ff       <= '0;
         clock_ff     <= '0;
         cap_ff       <= CAP_CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rd_pend_ff   <= rd_pend_in;
         occ_ff       <= occ_in;
         clock_ff     <= clock_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff    <= rd_idx_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
      if (accept) begin
         kind_ff <= req.kind;
         key_ff  <= req.key;
         wval_ff <= req.write_value;
      end
   end

endmodule
